// ===== src/lsa_pkg.sv =====
// Package for the LIFO stack allocator: field widths, status and register codes,
// header stack entry type and stack command struct. No dependencies.
`default_nettype none
package lsa_pkg;

  localparam int ADDR_W   = 32;
  localparam int ALIGN_W  = 13;
  localparam int ADJ_W    = 13;
  localparam int STAT_W   = 3;
  localparam int LIVE_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ARG  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_LAST = 3'd3;
  localparam logic [STAT_W-1:0] ST_STACK    = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL  = 1'b1;

  // one header stack entry: block that was last before the push, and the pushed block's adjustment
  typedef struct packed {
    logic [ADDR_W-1:0] prev;
    logic [ADJ_W-1:0]  adj;
  } hdr_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage
`default_nettype wire

// ===== src/lifo_stack_allocator.sv =====
// LIFO bump allocator with an alignment header stack; top level.
// Depends on lsa_pkg and lsa_hdr_stack.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_ready  kind, request_size, alignment, free_address
//   out      output     out_valid/out_ready block_address, status, used_bytes, live_count
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// One item per cycle unless stalled; its result shows the cycle after acceptance in the
// output register. in_ready is low only while a result waits and out_ready is low.
// The top header entry is a register; the one below is prefetched from the RAM each cycle.
// Reset empties the region with start address and pool size zero; no clearing pass.
`default_nettype none
module lifo_stack_allocator #(
  parameter int MAX_LIVE     = 64,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_ALIGN    = 4096
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_kind,
  input  wire [lsa_pkg::ADDR_W-1:0]        in_request_size,
  input  wire [lsa_pkg::ALIGN_W-1:0]       in_alignment,
  input  wire [lsa_pkg::ADDR_W-1:0]        in_free_address,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [lsa_pkg::ADDR_W-1:0]       out_block_address,
  output logic [lsa_pkg::STAT_W-1:0]       out_status,
  output logic [lsa_pkg::ADDR_W-1:0]       out_used_bytes,
  output logic [lsa_pkg::LIVE_W-1:0]       out_live_count,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [lsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [lsa_pkg::ADDR_W-1:0]        cfg_data
);
  import lsa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LIVE + 1);
  localparam int CALC_W = ADJ_W + 1;
  localparam int SUM_W  = ADDR_W + 2;

  logic [ADDR_W-1:0] pool_r, pool_nxt;
  logic [ADDR_W-1:0] top_r, top_nxt;
  logic [ADDR_W-1:0] last_r, last_nxt;
  logic [ADDR_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [STAT_W-1:0] out_stat_r;
  logic [ADDR_W-1:0] out_used_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              acc;
  logic              cfg_we;
  logic [ALIGN_W-1:0] align_m1;
  logic              align_ok;
  logic [ALIGN_W-1:0] low_bits;
  logic [ALIGN_W-1:0] adj0;
  logic [CALC_W-1:0] need;
  logic [CALC_W-1:0] round_up;
  logic [CALC_W-1:0] adj;
  logic [SUM_W-1:0]  need_sum;
  logic              no_space;
  logic [ADDR_W-1:0] blk_addr;
  logic [ADDR_W-1:0] free_span;
  logic [STAT_W-1:0] stat;
  stk_cmd_t          cmd;
  hdr_t              push_hdr;
  hdr_t              top_hdr;

  assign acc       = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // adjustment: align the top, then leave room for the header below the block
  always_comb begin
    align_m1 = in_alignment - ALIGN_W'(1);
    align_ok = (in_alignment != '0) && ((in_alignment & align_m1) == '0) &&
               (32'(in_alignment) <= 32'(MAX_ALIGN));
    low_bits = top_r[ALIGN_W-1:0] & align_m1;
    adj0     = (in_alignment - low_bits) & align_m1;
    need     = CALC_W'(HEADER_BYTES) - {1'b0, adj0};
    round_up = (need + {1'b0, align_m1}) & ~{1'b0, align_m1};
    if ({1'b0, adj0} < CALC_W'(HEADER_BYTES)) begin
      adj = {1'b0, adj0} + round_up;
    end else begin
      adj = {1'b0, adj0};
    end
    need_sum  = {2'b00, used_r} + {2'b00, in_request_size} +
                {{(SUM_W-CALC_W){1'b0}}, adj};
    no_space  = need_sum >= {2'b00, pool_r};
    blk_addr  = top_r + {{(ADDR_W-ADJ_W){1'b0}}, adj[ADJ_W-1:0]};
    free_span = (top_r - in_free_address) + {{(ADDR_W-ADJ_W){1'b0}}, top_hdr.adj};
  end

  always_comb begin
    stat     = ST_OK;
    cmd      = '0;
    if (in_kind == KIND_ALLOC) begin
      if (in_request_size == '0 || !align_ok) begin
        stat = ST_BAD_ARG;
      end else if (cnt_r >= CNT_W'(MAX_LIVE)) begin
        stat = ST_STACK;
      end else if (no_space) begin
        stat = ST_NO_SPACE;
      end else begin
        cmd.push = acc;
      end
    end else begin
      if (cnt_r == '0) begin
        stat = ST_STACK;
      end else if (in_free_address != last_r) begin
        stat = ST_NOT_LAST;
      end else begin
        cmd.pop = acc;
      end
    end
    push_hdr.prev = last_r;
    push_hdr.adj  = adj[ADJ_W-1:0];
  end

  always_comb begin
    pool_nxt = pool_r;
    top_nxt  = top_r;
    last_nxt = last_r;
    used_nxt = used_r;
    cnt_nxt  = cnt_r;
    if (cmd.push) begin
      top_nxt  = blk_addr + in_request_size;
      last_nxt = blk_addr;
      used_nxt = need_sum[ADDR_W-1:0];
      cnt_nxt  = cnt_r + CNT_W'(1);
    end else if (cmd.pop) begin
      top_nxt  = in_free_address - {{(ADDR_W-ADJ_W){1'b0}}, top_hdr.adj};
      last_nxt = top_hdr.prev;
      used_nxt = used_r - free_span;
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
    if (cfg_we) begin
      case (cfg_index)
        REG_START: begin
          top_nxt  = cfg_data;
          last_nxt = '0;
          used_nxt = '0;
          cnt_nxt  = '0;
        end
        REG_POOL: begin
          pool_nxt = cfg_data;
        end
        default: begin
          pool_nxt = pool_r;
        end
      endcase
    end
  end

  lsa_hdr_stack #(
    .MAX_LIVE (MAX_LIVE)
  ) u_hdr_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cnt      (cnt_r),
    .push_hdr (push_hdr),
    .top_hdr  (top_hdr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= '0;
      top_r       <= '0;
      last_r      <= '0;
      used_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pool_r <= pool_nxt;
      top_r  <= top_nxt;
      last_r <= last_nxt;
      used_r <= used_nxt;
      cnt_r  <= cnt_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_addr_r <= cmd.push ? blk_addr : '0;
      out_stat_r <= stat;
      out_used_r <= used_nxt;
      out_cnt_r  <= cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_status        = out_stat_r;
  assign out_used_bytes    = out_used_r;
  assign out_live_count    = LIVE_W'(32'(out_cnt_r));

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_LIVE))
    else $error("live count above limit");

  a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stat_r != ST_OK) |-> out_addr_r == '0)
    else $error("error result carries an address");

  a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (stat != ST_OK) && !cfg_we |=> $stable(used_r) && $stable(cnt_r) &&
    $stable(top_r) && $stable(last_r))
    else $error("error item changed allocator state");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push && !cfg_we |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("allocate did not bump live count");
`endif

endmodule
`default_nettype wire

// ===== src/lsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lsa_ram #(
  parameter int WIDTH = 45,
  parameter int DEPTH = 64
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                         wdata,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/lsa_hdr_stack.sv =====
// Header stack: top entry held in a register, deeper entries in lsa_ram with the
// next-to-top entry prefetched every cycle. Depends on lsa_pkg, lsa_ram.
`default_nettype none
module lsa_hdr_stack #(
  parameter int MAX_LIVE = 64
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire lsa_pkg::stk_cmd_t                cmd,
  input  wire [$clog2(MAX_LIVE+1)-1:0]          cnt,
  input  wire lsa_pkg::hdr_t                    push_hdr,
  output lsa_pkg::hdr_t                         top_hdr
);
  import lsa_pkg::*;

  localparam int CNT_W = $clog2(MAX_LIVE + 1);
  localparam int IDX_W = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;

  hdr_t             top_r;
  hdr_t             top_nxt;
  hdr_t             below;
  logic [$bits(hdr_t)-1:0] ram_rdata;
  hdr_t             byp_data_r;
  logic             byp_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] wr_dif;
  logic [CNT_W-1:0] rd_dif;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             we;

  always_comb begin
    cnt_nxt = cnt;
    if (cmd.push) begin
      cnt_nxt = cnt + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt - CNT_W'(1);
    end
    wr_dif = cnt - CNT_W'(1);
    rd_dif = cnt_nxt - CNT_W'(2);
    wr_idx = wr_dif[IDX_W-1:0];
    rd_idx = rd_dif[IDX_W-1:0];
    // spill the current top into the RAM when a push covers it
    we     = cmd.push && (cnt != '0);
  end

  lsa_ram #(
    .WIDTH ($bits(hdr_t)),
    .DEPTH (MAX_LIVE)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_idx),
    .wdata (top_r),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // entry count-2, forwarded when it was written in the cycle it was read
  assign below = byp_r ? byp_data_r : hdr_t'(ram_rdata);

  always_comb begin
    top_nxt = top_r;
    if (cmd.push) begin
      top_nxt = push_hdr;
    end else if (cmd.pop) begin
      top_nxt = below;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= we && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    byp_data_r <= top_r;
  end

  assign top_hdr = top_r;

endmodule
`default_nettype wire

// ===== bench/lsa_checker.sv =====
`timescale 1ns / 100ps
// Result checker for lifo_stack_allocator: watches the request, result and register channels,
// predicts every result from its own copy of the allocator state and compares field by field.
// Depends on lsa_pkg.
module lsa_checker #(
  parameter int MAX_LIVE     = 64,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_ALIGN    = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_kind,
  input  logic [lsa_pkg::ADDR_W-1:0]    in_request_size,
  input  logic [lsa_pkg::ALIGN_W-1:0]   in_alignment,
  input  logic [lsa_pkg::ADDR_W-1:0]    in_free_address,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [lsa_pkg::ADDR_W-1:0]    out_block_address,
  input  logic [lsa_pkg::STAT_W-1:0]    out_status,
  input  logic [lsa_pkg::ADDR_W-1:0]    out_used_bytes,
  input  logic [lsa_pkg::LIVE_W-1:0]    out_live_count,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsa_pkg::ADDR_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            pending_count,
  output int                            checked_count,
  output logic [lsa_pkg::LIVE_W-1:0]    live_view,
  output logic [lsa_pkg::ADDR_W-1:0]    last_block_view,
  output logic [lsa_pkg::LIVE_W-1:0]    peak_live,
  output logic [4:0]                    status_seen
);
  import lsa_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] used;
    logic [LIVE_W-1:0] live;
  } grant_t;

  grant_t awaited_grants[$];

  logic [ADDR_W-1:0] pool_limit, top_ptr, last_blk, used_sum;
  logic [LIVE_W-1:0] live_blocks;
  hdr_t              header_mem [MAX_LIVE];

  assign live_view       = live_blocks;
  assign last_block_view = last_blk;

  // gap from top to the aligned address, at least HEADER_BYTES
  function automatic logic [ADDR_W-1:0] header_gap(logic [ADDR_W-1:0] top,
                                                   logic [ALIGN_W-1:0] align);
    logic [ADDR_W-1:0] a, gap, deficit;
    a   = 32'(align);
    gap = (~top + 32'd1) & (a - 32'd1);
    if (gap < HEADER_BYTES) begin
      deficit = HEADER_BYTES - gap;
      gap     = gap + ((deficit + a - 32'd1) / a) * a;
    end
    return gap;
  endfunction

  function automatic grant_t serve_request(logic kind, logic [ADDR_W-1:0] size,
                                           logic [ALIGN_W-1:0] align,
                                           logic [ADDR_W-1:0] faddr);
    grant_t            r;
    logic [ADDR_W-1:0] gap;
    logic [63:0]       demand;
    hdr_t              h;
    r.addr   = '0;
    r.status = ST_OK;
    if (kind == KIND_ALLOC) begin
      if (size == 0 || align == 0 || (align & (align - 1)) != 0 || 32'(align) > MAX_ALIGN) begin
        r.status = ST_BAD_ARG;
      end else if (live_blocks >= MAX_LIVE) begin
        r.status = ST_STACK;
      end else begin
        gap    = header_gap(top_ptr, align);
        demand = 64'(used_sum) + 64'(size) + 64'(gap);
        if (demand >= 64'(pool_limit)) begin
          r.status = ST_NO_SPACE;
        end else begin
          h.prev                   = last_blk;
          h.adj                    = gap[ADJ_W-1:0];
          header_mem[live_blocks]  = h;
          r.addr                   = top_ptr + gap;
          last_blk                 = r.addr;
          top_ptr                  = r.addr + size;
          used_sum                 = used_sum + size + gap;
          live_blocks              = live_blocks + 1'b1;
        end
      end
    end else begin
      if (live_blocks == 0) begin
        r.status = ST_STACK;
      end else if (faddr != last_blk) begin
        r.status = ST_NOT_LAST;
      end else begin
        h           = header_mem[live_blocks - 1'b1];
        used_sum    = used_sum - ((top_ptr - faddr) + 32'(h.adj));
        live_blocks = live_blocks - 1'b1;
        top_ptr     = faddr - 32'(h.adj);
        last_blk    = h.prev;
      end
    end
    r.used = used_sum;
    r.live = live_blocks;
    return r;
  endfunction

  task automatic match_field(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    grant_t predicted;
    if (!rst_n) begin
      pool_limit    = '0;
      top_ptr       = '0;
      last_blk      = '0;
      used_sum      = '0;
      live_blocks   = '0;
      awaited_grants.delete();
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      peak_live     = '0;
      status_seen   = '0;
    end else begin
      // results first: a result never belongs to the item accepted at the same edge
      if (out_valid && out_ready) begin
        if (awaited_grants.size() == 0) begin
          $display("%0t unexpected result: addr %h status %0d used %h live %0d", $time,
                   out_block_address, out_status, out_used_bytes, out_live_count);
          fail_count++;
        end else begin
          predicted = awaited_grants.pop_front();
          match_field("block_address", predicted.addr, out_block_address);
          match_field("status", 32'(predicted.status), 32'(out_status));
          match_field("used_bytes", predicted.used, out_used_bytes);
          match_field("live_count", 32'(predicted.live), 32'(out_live_count));
          checked_count++;
        end
      end
      if (in_valid && in_ready) begin
        predicted = serve_request(in_kind, in_request_size, in_alignment, in_free_address);
        awaited_grants.push_back(predicted);
        status_seen[predicted.status] = 1'b1;
        if (predicted.live > peak_live) peak_live = predicted.live;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_START) begin
          top_ptr     = cfg_data;
          last_blk    = '0;
          used_sum    = '0;
          live_blocks = '0;
        end else begin
          pool_limit = cfg_data;
        end
      end
      pending_count = awaited_grants.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the allocator bench: clock, reset, request and register stimulus, result-side stalls.
// Depends on lsa_pkg, lifo_stack_allocator and lsa_checker.
module testbench;
  import lsa_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = KIND_ALLOC;
  logic [ADDR_W-1:0]    in_request_size = '0;
  logic [ALIGN_W-1:0]   in_alignment = '0;
  logic [ADDR_W-1:0]    in_free_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    out_block_address;
  logic [STAT_W-1:0]    out_status;
  logic [ADDR_W-1:0]    out_used_bytes;
  logic [LIVE_W-1:0]    out_live_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START;
  logic [ADDR_W-1:0]    cfg_data = '0;

  int                   fail_count, pending_count, checked_count;
  logic [LIVE_W-1:0]    live_view, peak_live;
  logic [ADDR_W-1:0]    last_block_view;
  logic [4:0]           status_seen;

  int                   items_sent = 0;
  int                   reg_writes = 0;
  int                   idle_cycles = 0;
  bit                   hold_request = 1'b0;
  bit                   hold_done = 1'b0;

  always #1 clk = ~clk;

  lifo_stack_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_request_size(in_request_size), .in_alignment(in_alignment),
    .in_free_address(in_free_address),
    .out_valid(out_valid), .out_ready(out_ready), .out_block_address(out_block_address),
    .out_status(out_status), .out_used_bytes(out_used_bytes), .out_live_count(out_live_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lsa_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_request_size(in_request_size), .in_alignment(in_alignment),
    .in_free_address(in_free_address),
    .out_valid(out_valid), .out_ready(out_ready), .out_block_address(out_block_address),
    .out_status(out_status), .out_used_bytes(out_used_bytes), .out_live_count(out_live_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count), .checked_count(checked_count),
    .live_view(live_view), .last_block_view(last_block_view), .peak_live(peak_live),
    .status_seen(status_seen)
  );

  // watchdog: any accepted item, taken result or register write restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t timeout, %0d results still awaited", $time, pending_count);
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: stall patterns per segment, plus one long hold-off on request
  initial begin
    int seg, mode, k;
    wait (rst_n);
    forever begin
      seg  = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      for (k = 0; k < seg; k++) begin
        @(negedge clk);
        if (hold_request && !hold_done) begin
          out_ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 9) < 7);
          2: out_ready = ($urandom_range(0, 9) < 3);
          default: out_ready = (k % 4 == 0);
        endcase
      end
    end
  end

  // called at a falling edge; holds the item until accepted
  task automatic drive_request(logic k, logic [ADDR_W-1:0] sz, logic [ALIGN_W-1:0] al,
                               logic [ADDR_W-1:0] fa);
    in_kind         = k;
    in_request_size = sz;
    in_alignment    = al;
    in_free_address = fa;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic alloc_req(logic [ADDR_W-1:0] sz, logic [ALIGN_W-1:0] al);
    @(negedge clk);
    drive_request(KIND_ALLOC, sz, al, $urandom);
  endtask

  // free at last block + offset; offset zero is the well-formed free
  task automatic free_req(logic [ADDR_W-1:0] offset);
    @(negedge clk);
    drive_request(KIND_FREE, $urandom, ALIGN_W'($urandom), last_block_view + offset);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // called at a falling edge so the checker's view of the last block is current
  task automatic issue_random(int alloc_pct);
    int                 roll;
    logic               k;
    logic [ADDR_W-1:0]  sz, fa;
    logic [ALIGN_W-1:0] al;
    roll = $urandom_range(0, 99);
    k    = KIND_ALLOC;
    sz   = $urandom;
    al   = ALIGN_W'($urandom);
    fa   = $urandom;
    if (roll < 5) begin
      case ($urandom_range(0, 2))
        0: begin
          sz = '0;
          al = ALIGN_W'(1) << $urandom_range(0, 12);
        end
        1: al = '0;
        default: al = ALIGN_W'($urandom_range(0, 8191));
      endcase
    end else if (roll < 5 + alloc_pct) begin
      al = ALIGN_W'(1) << $urandom_range(0, 12);
      case ($urandom_range(0, 9))
        7, 8: sz = $urandom_range(1, 4096);
        9: sz = $urandom;
        default: sz = $urandom_range(1, 64);
      endcase
    end else begin
      k = KIND_FREE;
      if ($urandom_range(0, 9) < 8) fa = last_block_view;
    end
    drive_request(k, sz, al, fa);
  endtask

  task automatic run_phase(int count, int alloc_pct, bit gaps_on);
    int n, burst;
    burst = 0;
    for (n = 0; n < count; n++) begin
      if (gaps_on && burst == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
        burst = $urandom_range(1, 40);
      end
      if (burst > 0) burst--;
      @(negedge clk);
      issue_random(alloc_pct);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset values: empty pool, empty stack
    alloc_req(32'd1, 13'd1);
    free_req('0);
    settle();
    program_reg(REG_START, 32'h0000_1003);
    program_reg(REG_POOL, 32'h0001_0000);

    alloc_req(32'd0, 13'd8);
    alloc_req(32'd10, 13'd0);
    alloc_req(32'd10, 13'd12);
    alloc_req(32'd10, 13'h1FFF);
    alloc_req(32'd100, 13'd1);
    alloc_req(32'd33, 13'd4096);
    alloc_req(32'd5, 13'd32);
    free_req(32'd1);
    free_req('0);
    free_req('0);
    free_req('0);
    free_req('0);
    alloc_req(32'hFFFF_FFFF, 13'd1);
    // with alignment 1 the header gap is 16: this one just misses, the next fits
    alloc_req(32'h0001_0000 - 32'd16, 13'd1);
    alloc_req(32'h0001_0000 - 32'd17, 13'd1);
    free_req('0);
    settle();

    // region at the very top of the address space: the first block wraps to zero
    program_reg(REG_START, 32'hFFFF_FFF0);
    program_reg(REG_POOL, 32'hFFFF_FFFF);
    alloc_req(32'h40, 13'd64);
    alloc_req(32'hFFFF_0000, 13'd4096);
    free_req(32'h8000_0000);
    free_req('0);
    free_req('0);
    settle();

    program_reg(REG_START, 32'h0);
    program_reg(REG_POOL, 32'hFFFF_FFFF);
    run_phase(230, 80, 1'b1);
    settle();

    program_reg(REG_START, $urandom);
    program_reg(REG_POOL, $urandom_range(256, 8192));
    hold_request = 1'b1;
    run_phase(220, 50, 1'b1);
    settle();

    program_reg(REG_START, 32'hFFFF_F800);
    program_reg(REG_POOL, 32'h0001_0000);
    run_phase(220, 60, 1'b0);
    settle();

    // limit change only: live blocks stay
    program_reg(REG_POOL, $urandom_range(0, 4096));
    run_phase(200, 45, 1'b1);
    settle();

    program_reg(REG_START, $urandom);
    program_reg(REG_POOL, $urandom);
    run_phase(230, 55, 1'b1);
    settle();

    $display("Covered %0d requests and %0d register writes; %0d results checked.",
             items_sent, reg_writes, checked_count);
    $display("Peak live blocks %0d, status codes seen (4..0) %b.", peak_live, status_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lsa_pkg.sv
src/lsa_ram.sv
src/lsa_hdr_stack.sv
src/lifo_stack_allocator.sv
bench/lsa_checker.sv
bench/testbench.sv
